// ===== src/rwc_pkg.sv =====
`default_nettype none

package rwc_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DEPTH_MAX = 64;
	localparam int SAMPLE_W = 32;
	localparam int REQ_W = 16;
	localparam int WIN_W = 7;

	typedef struct packed {
		logic [SAMPLE_W-1:0]     sample_in;
		logic signed [REQ_W-1:0] window_length;
	} in_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic [WIN_W-1:0]    window_used;
		logic                is_last;
	} out_word_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

`default_nettype wire

// ===== src/rwc_ring.sv =====
`default_nettype none

module rwc_ring #(
	parameter int DEPTH = rwc_pkg::DEPTH_DEF,
	parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [PTR_W-1:0]             wr_addr,
	input  wire logic [rwc_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic                         rd_en,
	input  wire logic [PTR_W-1:0]             rd_addr,
	output logic      [rwc_pkg::SAMPLE_W-1:0] rd_data
);

	logic [rwc_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]             written_q;
	logic [rwc_pkg::SAMPLE_W-1:0] rd_data_q;
	logic                         rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	// slots never written read as zero
	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== src/rolling_window_capture.sv =====
// Each accepted input word produces window_used output words, oldest sample first.
// The first output word follows acceptance through ST_RUN, the ring read register and
// the output buffer. Input is stalled while the readout runs: one ring read per cycle
// while the output buffer has room, 1..DEPTH reads per input word.
// Async active-low reset clears the write pointer, the sequencer and the per-slot
// written flags, so unwritten slots read as zero; no clearing pass is needed.
`default_nettype none

module rolling_window_capture #(
	parameter int DEPTH = rwc_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rwc_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rwc_pkg::out_word_t      out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [rwc_pkg::WIN_W-1:0] LEN_MAX = rwc_pkg::WIN_W'(DEPTH);
	localparam logic [rwc_pkg::WIN_W:0] DEPTH_X = (rwc_pkg::WIN_W + 1)'(DEPTH);

	rwc_pkg::state_t state_q, state_d;

	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           wp_next;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [rwc_pkg::WIN_W-1:0]  remain_q;
	logic [rwc_pkg::WIN_W-1:0]  len_q;
	logic [rwc_pkg::WIN_W-1:0]  len_d;
	logic [rwc_pkg::WIN_W:0]    start_sum;
	logic [PTR_W-1:0]           start_d;
	logic                       in_acc;
	logic                       issue;
	logic                       issue_last;
	logic                       rd_vld_s1;
	logic                       last_s1;
	logic [rwc_pkg::WIN_W-1:0]  len_s1;
	logic [rwc_pkg::SAMPLE_W-1:0] rd_data;

	rwc_pkg::out_word_t fifo_q [2];
	logic               fifo_wr_q;
	logic               fifo_rd_q;
	logic [1:0]         count_q;
	logic               pop;
	logic [2:0]         credit;

	assign in_acc = in_valid && !in_stall;
	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;

	// clamp the request to 1..DEPTH
	always_comb begin
		priority if (in_data.window_length < 16'sd1) begin
			len_d = rwc_pkg::WIN_W'(1);
		end else if (in_data.window_length > $signed(rwc_pkg::REQ_W'(DEPTH))) begin
			len_d = LEN_MAX;
		end else begin
			len_d = in_data.window_length[rwc_pkg::WIN_W-1:0];
		end
	end

	// oldest slot of the window
	always_comb begin
		start_sum = (rwc_pkg::WIN_W + 1)'(wp_next) + DEPTH_X - {1'b0, len_d};
		if (start_sum >= DEPTH_X) begin
			start_d = PTR_W'(start_sum - DEPTH_X);
		end else begin
			start_d = PTR_W'(start_sum);
		end
	end

	assign pop = out_valid && !out_stall;
	assign credit = {1'b0, count_q} + {2'b00, rd_vld_s1} - {2'b00, pop};

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		issue      = 1'b0;
		issue_last = (remain_q == rwc_pkg::WIN_W'(1));
		unique case (state_q)
			rwc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = rwc_pkg::ST_RUN;
				end
			end
			rwc_pkg::ST_RUN: begin
				issue = (credit < 3'd2);
				if (issue && issue_last) begin
					state_d = rwc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rwc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rwc_pkg::ST_IDLE;
			wp_q      <= '0;
			remain_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (in_acc) begin
				wp_q     <= wp_next;
				remain_q <= len_d;
			end else if (issue) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_ptr_q <= start_d;
			len_q    <= len_d;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
		end
		if (issue) begin
			last_s1 <= issue_last;
			len_s1  <= len_q;
		end
	end

	rwc_ring #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc),
		.wr_addr (wp_q),
		.wr_data (in_data.sample_in),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// two-entry output buffer decouples reads from the output stall
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			fifo_q[fifo_wr_q] <= '{sample_out: rd_data, window_used: len_s1, is_last: last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wr_q <= 1'b0;
			fifo_rd_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (rd_vld_s1) begin
				fifo_wr_q <= !fifo_wr_q;
			end
			if (pop) begin
				fifo_rd_q <= !fifo_rd_q;
			end
			count_q <= credit[1:0];
		end
	end

	assign out_valid = (count_q != 2'd0);
	assign out_data  = fifo_q[fifo_rd_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("output buffer overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && !pop |-> count_q < 2'd2)
		else $error("read lands in a full buffer");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rwc_pkg::ST_IDLE |-> remain_q == '0)
		else $error("readout left unfinished");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		issue && issue_last |=> state_q == rwc_pkg::ST_IDLE)
		else $error("run continues after last read");

endmodule

`default_nettype wire

// ===== tb/rolling_window_capture_test.sv =====
`timescale 1ns / 100ps

module rolling_window_capture_test;

	localparam int DEPTH = rwc_pkg::DEPTH_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int TAIL_CYCLES = 2 * DEPTH + 12;

	class window_scoreboard;
		rwc_pkg::out_word_t window_q[$];
		logic [rwc_pkg::SAMPLE_W-1:0] ring[DEPTH];
		int unsigned wr_idx;
		int errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_idx = 0;
			errors = 0;
		endfunction

		function void note_sample(rwc_pkg::in_word_t w);
			int req;
			int len;
			int first;
			rwc_pkg::out_word_t e;
			req = $signed(w.window_length);
			ring[wr_idx] = w.sample_in;
			wr_idx = (wr_idx + 1) % DEPTH;
			if (req < 1) begin
				len = 1;
			end else if (req > DEPTH) begin
				len = DEPTH;
			end else begin
				len = req;
			end
			first = (wr_idx + DEPTH - len) % DEPTH;
			for (int i = 0; i < len; i++) begin
				e.sample_out = ring[(first + i) % DEPTH];
				e.window_used = len[rwc_pkg::WIN_W-1:0];
				e.is_last = (i == len - 1);
				window_q.push_back(e);
			end
		endfunction

		function void check_word(rwc_pkg::out_word_t got);
			rwc_pkg::out_word_t e;
			if (window_q.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			e = window_q.pop_front();
			if (got.sample_out !== e.sample_out) begin
				$error("sample_out: expected %h, actual %h", e.sample_out, got.sample_out);
				errors++;
			end
			if (got.window_used !== e.window_used) begin
				$error("window_used: expected %0d, actual %0d", e.window_used, got.window_used);
				errors++;
			end
			if (got.is_last !== e.is_last) begin
				$error("is_last: expected %0d, actual %0d", e.is_last, got.is_last);
				errors++;
			end
		endfunction

		function int pending();
			return window_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rwc_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rwc_pkg::out_word_t out_data;

	window_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	rolling_window_capture #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall = 1'b0;
		end else if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_word(out_data);
			if (in_valid && !in_stall) sb.note_sample(in_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(input rwc_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			in_data = {$urandom, 16'($urandom)};
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic rwc_pkg::in_word_t rand_word();
		rwc_pkg::in_word_t w;
		int unsigned pick;
		w.sample_in = $urandom;
		pick = $urandom_range(99);
		if (pick < 50) begin
			w.window_length = 16'($urandom_range(8, 1));
		end else if (pick < 75) begin
			w.window_length = 16'($urandom_range(DEPTH, 1));
		end else if (pick < 90) begin
			w.window_length = 16'($urandom);
		end else begin
			case ($urandom_range(3))
				0: w.window_length = 16'sd0;
				1: w.window_length = -16'sd1;
				2: w.window_length = 16'(DEPTH + 1);
				default: w.window_length = 16'(DEPTH);
			endcase
		end
		return w;
	endfunction

	task automatic run_directed();
		int lens[20];
		logic [rwc_pkg::SAMPLE_W-1:0] pats[4];
		rwc_pkg::in_word_t w;
		lens = '{64, 0, -1, -32768, 1, 2, 63, 64, 65, 32767,
			3, 64, -2, 100, 1, 5, 64, 32, -32767, 64};
		pats = '{32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};
		for (int i = 0; i < 20; i++) begin
			w.sample_in = (i < 4) ? pats[i] : (pats[i % 4] ^ i);
			w.window_length = lens[i][rwc_pkg::REQ_W-1:0];
			send_word(w);
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 68; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 68; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			if (ph == 0) hold_left = HOLD_CYCLES;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) send_word(rand_word());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/rwc_pkg.sv
src/rwc_ring.sv
src/rolling_window_capture.sv
tb/rolling_window_capture_test.sv
